[rtl/core/ufp_pkg.sv]
// ----------------------------------------------------------------------------
// ufp_pkg
// Shared types and constants for the form-urlencoded stream parser.
// ----------------------------------------------------------------------------
package ufp_pkg;

    // Special characters of the query syntax
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;

    // Most results one input beat can produce
    localparam int MAX_RES     = 5;
    localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
    // Default depth of the front-to-back bundle queue
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_PAIR  = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    // Input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_beat;

    // One decoded result inside a bundle
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_result;

    // All results of one input beat, slot 0 first
    typedef struct packed {
        logic [RES_CNT_W-1:0]      count;
        t_result [MAX_RES-1:0]     res;
    } t_bundle;

endpackage

[rtl/core/ufp_front.sv]
// ----------------------------------------------------------------------------
// ufp_front
// Parser state and per-byte classification; turns each accepted byte into
// a bundle of up to MAX_RES results.
// ----------------------------------------------------------------------------
module ufp_front import ufp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_beat i_in,
    output t_bundle  o_bundle,
    output logic     o_bundle_valid
);

    // Escape decoder states
    typedef enum logic [2:0] {
        PEND_NONE  = 3'b001,
        PEND_PCT   = 3'b010,
        PEND_DIGIT = 3'b100
    } t_pend;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c <= 8'h46) begin
            t = c - 8'h37;
        end else begin
            t = c - 8'h57;
        end
        hex_nib = t[3:0];
    endfunction

    logic       r_value_half, n_value_half;
    logic       r_nonempty,   n_nonempty;
    t_pend      r_pend,       n_pend;
    logic [7:0] r_held,       n_held;

    t_bundle    bundle;

    // Classify the byte and list its results in order
    always_comb begin
        logic [7:0]           c;
        logic                 hv;
        logic                 is_amp;
        logic                 is_split;
        logic                 dec;
        logic                 flush1;
        logic                 complete;
        logic                 hold;
        logic                 char_path;
        t_kind                hk;
        t_kind                hk2;
        t_pend                pend_mid;
        logic [7:0]           held_mid;
        logic                 vh_mid;
        logic                 ne_mid;
        logic [RES_CNT_W-1:0] n;

        c         = (i_in.in_byte == CH_PLUS) ? CH_SPACE : i_in.in_byte;
        hv        = is_hex(c);
        is_amp    = (i_in.in_byte == CH_AMP);
        is_split  = !is_amp && (i_in.in_byte == CH_EQ) && !r_value_half;
        dec       = !is_amp && !is_split;
        flush1    = is_amp || is_split || (dec && (r_pend != PEND_NONE) && !hv);
        complete  = dec && (r_pend == PEND_DIGIT) && hv;
        hold      = dec && (r_pend == PEND_PCT) && hv;
        char_path = dec && !complete && !hold;
        hk        = r_value_half ? KIND_VALUE : KIND_NAME;

        // State after the byte itself
        pend_mid = r_pend;
        if (flush1 || complete) begin
            pend_mid = PEND_NONE;
        end
        if (hold) begin
            pend_mid = PEND_DIGIT;
        end
        if (char_path && (c == CH_PCT)) begin
            pend_mid = PEND_PCT;
        end
        held_mid = hold ? c : r_held;
        vh_mid   = is_amp ? 1'b0 : (is_split ? 1'b1 : r_value_half);
        ne_mid   = !is_amp;
        hk2      = vh_mid ? KIND_VALUE : KIND_NAME;

        bundle = '0;
        n      = '0;
        // Flush of a broken or cut escape
        if (flush1 && (r_pend != PEND_NONE)) begin
            bundle.res[n[2:0]] = '{kind: hk, data: CH_PCT};
            n = n + 1'b1;
        end
        if (flush1 && (r_pend == PEND_DIGIT)) begin
            bundle.res[n[2:0]] = '{kind: hk, data: r_held};
            n = n + 1'b1;
        end
        // Decoded escape or plain byte
        if (complete) begin
            bundle.res[n[2:0]] = '{kind: hk, data: {hex_nib(r_held), hex_nib(c)}};
            n = n + 1'b1;
        end
        if (char_path && (c != CH_PCT)) begin
            bundle.res[n[2:0]] = '{kind: hk, data: c};
            n = n + 1'b1;
        end
        // Separator closes a pair that holds bytes
        if (is_amp && r_nonempty) begin
            bundle.res[n[2:0]] = '{kind: KIND_PAIR, data: 8'h00};
            n = n + 1'b1;
        end
        // End of query
        if (i_in.last_byte) begin
            if (pend_mid != PEND_NONE) begin
                bundle.res[n[2:0]] = '{kind: hk2, data: CH_PCT};
                n = n + 1'b1;
            end
            if (pend_mid == PEND_DIGIT) begin
                bundle.res[n[2:0]] = '{kind: hk2, data: held_mid};
                n = n + 1'b1;
            end
            if (ne_mid) begin
                bundle.res[n[2:0]] = '{kind: KIND_PAIR, data: 8'h00};
                n = n + 1'b1;
            end
            bundle.res[n[2:0]] = '{kind: KIND_DONE, data: 8'h00};
            n = n + 1'b1;
        end
        bundle.count = n;

        n_pend       = i_in.last_byte ? PEND_NONE : pend_mid;
        n_held       = held_mid;
        n_value_half = i_in.last_byte ? 1'b0 : vh_mid;
        n_nonempty   = i_in.last_byte ? 1'b0 : ne_mid;
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_half <= 1'b0;
            r_nonempty   <= 1'b0;
            r_pend       <= PEND_NONE;
        end else if (i_accept) begin
            r_value_half <= n_value_half;
            r_nonempty   <= n_nonempty;
            r_pend       <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

    // Beats with no result push nothing
    assign o_bundle       = bundle;
    assign o_bundle_valid = i_accept && (bundle.count != '0);

endmodule

[rtl/core/ufp_queue.sv]
// ----------------------------------------------------------------------------
// ufp_queue
// Small bundle queue between the front and back parts.
// ----------------------------------------------------------------------------
module ufp_queue import ufp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_bundle i_wdata,
    output logic    o_full,
    input  logic    i_rd,
    output t_bundle o_rdata,
    output logic    o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_bundle          mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             wr_en, rd_en;

    assign wr_en = i_wr && !o_full;
    assign rd_en = i_rd && !o_empty;

    // Pointer and occupancy update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (wr_en) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata = mem[r_rptr];
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);

endmodule

[rtl/core/ufp_back.sv]
// ----------------------------------------------------------------------------
// ufp_back
// Walks the head bundle one result per cycle into the output register unless pop stalls it.
// ----------------------------------------------------------------------------
module ufp_back import ufp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bundle   i_q_data,
    input  logic      i_q_empty,
    output logic      o_q_rd,
    output t_out_beat o_out,
    output logic      o_empty,
    input  logic      i_pop
);

    logic [RES_CNT_W-1:0] r_idx, n_idx;
    logic                 r_valid, n_valid;
    t_out_beat            r_out;
    logic                 load;
    logic                 is_last;
    t_result              cur;

    // Load when the output slot is free or being drained this cycle
    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign cur     = i_q_data.res[r_idx[2:0]];
    assign is_last = (r_idx == i_q_data.count - 1'b1);

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid && !i_pop;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = is_last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= '{kind: cur.kind, out_byte: cur.data, last_of_run: is_last};
        end
    end

    assign o_q_rd  = load && is_last;
    assign o_out   = r_out;
    assign o_empty = !r_valid;

endmodule

[rtl/core/form_urlencoded_stream_parser.sv]
// ----------------------------------------------------------------------------
// form_urlencoded_stream_parser
// Streaming application/x-www-form-urlencoded decoder, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one query byte per cycle and returns a stream of decoded name bytes,
// value bytes, pair-complete markers and a query-finished marker; the last
// result of each input byte carries last_of_run. The front part decodes a
// byte in the cycle it is accepted and writes all of its results as one
// bundle into a QUEUE_DEPTH_P-entry queue; bytes that give no result (a held
// '%' or hex digit) write nothing. The back part sends one result per cycle
// from an output register while popped, so a byte with n results holds the
// back part until all n are sent and the input keeps flowing at one byte per
// cycle as long as the output is popped and the bytes give at most one result
// each. Input stalls (full) only while the queue is full, e.g. during a burst
// of escape flushes and end markers.
module form_urlencoded_stream_parser import ufp_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in,
    input  logic      push,
    output logic      full,
    output t_out_beat o_out,
    output logic      empty,
    input  logic      pop
);

    logic    accept;
    t_bundle fr_bundle;
    logic    fr_valid;
    t_bundle q_data;
    logic    q_empty;
    logic    q_rd;
    logic    q_full;

    assign accept = push && !q_full;
    assign full   = q_full;

    // Front: byte classification and parser state
    ufp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in           (i_in),
        .o_bundle       (fr_bundle),
        .o_bundle_valid (fr_valid)
    );

    // Bundle queue
    ufp_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fr_valid),
        .i_wdata (fr_bundle),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_data),
        .o_empty (q_empty)
    );

    // Back: result serializer
    ufp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_data),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .o_out     (o_out),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

[rtl/core/ufp_checker.sv]
// ----------------------------------------------------------------------------
// ufp_checker
// Port-level checks for the form-urlencoded stream parser.
// ----------------------------------------------------------------------------
module ufp_checker import ufp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input logic      full,
    input t_out_beat o_out,
    input logic      empty,
    input logic      pop
);

    // Reset leaves no result waiting and room for input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("parser not clear after reset");

    // Query-finished is always the final result of its byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.kind == KIND_DONE) |-> o_out.last_of_run)
        else $error("query-finished beat without last_of_run");

    // Markers carry a zero byte
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out.kind == KIND_PAIR || o_out.kind == KIND_DONE))
        |-> (o_out.out_byte == 8'h00))
        else $error("marker beat with nonzero byte");

    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("result beat changed while stalled");

    // Input side is not full right after reset, even with push held in reset
    a_push_reset: assert property (@(posedge i_clk)
        (!i_rst_n && push) |=> !full)
        else $error("input full right after reset");

endmodule

bind form_urlencoded_stream_parser ufp_checker u_ufp_checker (.*);
